### rtl/assert_macros.svh
// Assertion helper macros for the ray-sphere shader RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is asserted.
`define RSDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsds check failed");

// Condition that must never hold, disabled while reset is asserted.
`define RSDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rsds check failed");

`endif

### rtl/rsds_pkg.sv
// Shared types and constants for the ray-sphere diffuse shader.
// No dependencies.
package rsds_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    // Widths of the configuration registers.
    localparam int CFG_W = 11;
    localparam int RAD_W = 10;

    localparam logic [CFG_W-1:0] SPHERE_X_RST = 11'd250;
    localparam logic [CFG_W-1:0] SPHERE_Y_RST = 11'd250;
    localparam logic [CFG_W-1:0] SPHERE_Z_RST = 11'd50;
    localparam logic [RAD_W-1:0] RADIUS_RST   = 10'd50;
    localparam logic [CFG_W-1:0] LIGHT_X_RST  = 11'd0;
    localparam logic [CFG_W-1:0] LIGHT_Y_RST  = 11'd0;
    localparam logic [CFG_W-1:0] LIGHT_Z_RST  = 11'd50;

    localparam logic [7:0] RED_UNLIT = 8'd127;

    typedef enum logic [2:0] {
        REG_SPHERE_X,
        REG_SPHERE_Y,
        REG_SPHERE_Z,
        REG_RADIUS,
        REG_LIGHT_X,
        REG_LIGHT_Y,
        REG_LIGHT_Z
    } reg_idx_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

endpackage

### rtl/rsds_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband payload alongside; standalone, no package needed.
module rsds_isqrt #(
    parameter int IN_W  = 52,
    parameter int PAY_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [IN_W-1:0]          in_rad,
    input  logic [PAY_W-1:0]         in_pay,
    output logic                     out_valid,
    output logic [(IN_W+1)/2-1:0]    out_root,
    output logic [PAY_W-1:0]         out_pay
);

    localparam int RW  = (IN_W + 1) / 2;
    localparam int EW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic [EW-1:0]    rad_reg  [RW];
    logic [EW-1:0]    rad_next [RW];
    logic [RMW-1:0]   rem_reg  [RW];
    logic [RMW-1:0]   rem_next [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [RW-1:0]    root_next[RW];
    logic [PAY_W-1:0] pay_reg  [RW];
    logic [RW-1:0]    vld_reg;

    // Restoring digit-by-digit root: each stage brings down the next bit pair.
    always_comb
    begin
        logic [EW-1:0]  src_rad;
        logic [RMW-1:0] src_rem;
        logic [RW-1:0]  src_root;
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                src_rad  = EW'(in_rad);
                src_rem  = '0;
                src_root = '0;
            end
            else
            begin
                src_rad  = rad_reg[k-1];
                src_rem  = rem_reg[k-1];
                src_root = root_reg[k-1];
            end
            rem_t = {src_rem[RMW-3:0], src_rad[EW-1 -: 2]};
            trial = {src_root, 2'b01};
            if (rem_t >= trial)
            begin
                rem_next[k]  = rem_t - trial;
                root_next[k] = {src_root[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_t;
                root_next[k] = {src_root[RW-2:0], 1'b0};
            end
            rad_next[k] = {src_rad[EW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RW; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                pay_reg[k]  <= (k == 0) ? in_pay : pay_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RW-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

endmodule

### rtl/ray_sphere_diffuse_shader.sv
// Top level of the ray-sphere diffuse shader: APB registers, the shading
// pipeline and the output queue. Uses rsds_pkg, rsds_isqrt, assert_macros.svh.
//
// Usage: each input beat on s_axis carries one pixel coordinate; the ray runs
// from (pixel_x, pixel_y, 0) along +z. Exactly one output beat on m_axis comes
// back per pixel, in order: tdata holds red, green, blue and tuser the hit
// flag. A miss gives black with hit low.
// One pixel can enter every clock while s_axis_tready is high. From the input
// beat to the output the path runs through stages A to C, the discriminant
// square root, D to G, the light-distance square root, H to J, the divider
// and the output queue; the two bit-per-stage square roots make up most of it.
// The pipeline moves as one; a two-beat output queue behind it keeps input
// flowing while a finished beat waits. When the receiver stalls and the queue
// fills, the pipeline holds and s_axis_tready drops; nothing is lost.
// The user must write the registers over APB only while the block is idle; the block
// does not enforce this. Byte addresses 0, 4, ... 24 hold sphere x, y, z, radius,
// light x, y, z. Reset loads the default sphere and light, empties pipeline and queue.
`include "assert_macros.svh"

module ray_sphere_diffuse_shader
    import rsds_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Pixel input; tdata: pixel_x, pixel_y, zero fill
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // Shaded output; tdata: red, green, blue; tuser: hit
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,
    output logic [0:0]                          m_axis_tuser
);

    localparam int CB     = COORD_BITS;
    localparam int FB     = FRAC_BITS;
    localparam int DW     = ((CB > CFG_W) ? CB : CFG_W) + 2;
    localparam int PW2    = 2 * DW;
    localparam int QW     = 2 * DW + 2;
    localparam int QPW    = 2 * RAD_W;
    localparam int S_IN   = QPW + 2 * FB;
    localparam int SW     = (S_IN + 1) / 2;
    localparam int EZW    = FB + CFG_W + 2;
    localparam int DXY_W  = 2 * DW + 1;
    localparam int EXY_W  = 2 * DW;
    localparam int PEZ_W  = EZW + SW;
    localparam int EZ2_W  = 2 * EZW;
    localparam int VW     = DXY_W + FB + 2;
    localparam int MW     = EXY_W + FB + 1;
    localparam int L_IN   = MW + FB;
    localparam int LW     = (L_IN + 1) / 2;
    localparam int DNW    = RAD_W + LW;
    localparam int RNW    = ((DNW + 1 > VW) ? DNW + 1 : VW) + 1;
    localparam int NW     = RNW + 8;
    localparam int DVW    = ((NW > DNW + 10) ? NW : DNW + 10) + 1;
    localparam int P1W    = 1 + DXY_W + EXY_W;
    localparam int P2W    = 1 + VW;
    localparam int NDIV   = 9;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] sphere_x_reg, sphere_y_reg, sphere_z_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [CFG_W-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [QPW-1:0]   rr_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_x_reg <= SPHERE_X_RST;
            sphere_y_reg <= SPHERE_Y_RST;
            sphere_z_reg <= SPHERE_Z_RST;
            radius_reg   <= RADIUS_RST;
            light_x_reg  <= LIGHT_X_RST;
            light_y_reg  <= LIGHT_Y_RST;
            light_z_reg  <= LIGHT_Z_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SPHERE_X: sphere_x_reg <= pwdata[CFG_W-1:0];
                REG_SPHERE_Y: sphere_y_reg <= pwdata[CFG_W-1:0];
                REG_SPHERE_Z: sphere_z_reg <= pwdata[CFG_W-1:0];
                REG_RADIUS:   radius_reg   <= pwdata[RAD_W-1:0];
                REG_LIGHT_X:  light_x_reg  <= pwdata[CFG_W-1:0];
                REG_LIGHT_Y:  light_y_reg  <= pwdata[CFG_W-1:0];
                REG_LIGHT_Z:  light_z_reg  <= pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SPHERE_X: prdata = 32'(sphere_x_reg);
            REG_SPHERE_Y: prdata = 32'(sphere_y_reg);
            REG_SPHERE_Z: prdata = 32'(sphere_z_reg);
            REG_RADIUS:   prdata = 32'(radius_reg);
            REG_LIGHT_X:  prdata = 32'(light_x_reg);
            REG_LIGHT_Y:  prdata = 32'(light_y_reg);
            REG_LIGHT_Z:  prdata = 32'(light_z_reg);
            default:      prdata = '0;
        endcase
    end

    // Radius squared only changes with the configuration.
    always_ff @(posedge clk)
    begin
        rr_reg <= QPW'(radius_reg) * QPW'(radius_reg);
    end

    // ---------------- pipeline control ----------------
    logic       en;
    logic       push;
    logic       pop;
    logic [1:0] cnt_reg;
    logic       in_beat;

    assign s_axis_tready = en;
    assign in_beat       = s_axis_tvalid & s_axis_tready;

    // ---------------- A: ray offsets ----------------
    logic                 a_vld_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg, a_ex_reg, a_ey_reg;
    logic signed [DW-1:0] px, py;

    assign px = DW'($signed({1'b0, s_axis_tdata[CB-1:0]}));
    assign py = DW'($signed({1'b0, s_axis_tdata[2*CB-1:CB]}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg <= px - DW'($signed(sphere_x_reg));
            a_dy_reg <= py - DW'($signed(sphere_y_reg));
            a_ex_reg <= DW'($signed(light_x_reg)) - px;
            a_ey_reg <= DW'($signed(light_y_reg)) - py;
        end
    end

    // ---------------- B: products ----------------
    logic                  b_vld_reg;
    logic signed [PW2-1:0] b_dx2_reg, b_dy2_reg, b_exdx_reg, b_eydy_reg;
    logic signed [PW2-1:0] b_ex2_reg, b_ey2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dx2_reg  <= PW2'(a_dx_reg) * PW2'(a_dx_reg);
            b_dy2_reg  <= PW2'(a_dy_reg) * PW2'(a_dy_reg);
            b_exdx_reg <= PW2'(a_ex_reg) * PW2'(a_dx_reg);
            b_eydy_reg <= PW2'(a_ey_reg) * PW2'(a_dy_reg);
            b_ex2_reg  <= PW2'(a_ex_reg) * PW2'(a_ex_reg);
            b_ey2_reg  <= PW2'(a_ey_reg) * PW2'(a_ey_reg);
        end
    end

    // ---------------- C: discriminant and sums ----------------
    logic                    c_vld_reg;
    logic                    c_hit_reg;
    logic [QPW-1:0]          c_q_reg;
    logic signed [DXY_W-1:0] c_dxy_reg;
    logic [EXY_W-1:0]        c_exy2_reg;
    logic signed [QW-1:0]    q_next;

    assign q_next = QW'(rr_reg) - QW'(b_dx2_reg) - QW'(b_dy2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_hit_reg  <= (q_next > 0);
            c_q_reg    <= q_next[QPW-1:0];
            c_dxy_reg  <= DXY_W'(b_exdx_reg) + DXY_W'(b_eydy_reg);
            c_exy2_reg <= EXY_W'(b_ex2_reg) + EXY_W'(b_ey2_reg);
        end
    end

    // ---------------- square root of the discriminant ----------------
    logic            s1_vld;
    logic [SW-1:0]   s1_root;
    logic [P1W-1:0]  s1_pay;
    logic [S_IN-1:0] s1_rad;

    assign s1_rad = c_hit_reg ? {c_q_reg, {(2*FB){1'b0}}} : '0;

    rsds_isqrt #(
        .IN_W  (S_IN),
        .PAY_W (P1W)
    ) u_sqrt_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_vld_reg),
        .in_rad    (s1_rad),
        .in_pay    ({c_hit_reg, c_dxy_reg, c_exy2_reg}),
        .out_valid (s1_vld),
        .out_root  (s1_root),
        .out_pay   (s1_pay)
    );

    // ---------------- D: light vector z ----------------
    logic                    d_vld_reg;
    logic signed [EZW-1:0]   d_ez_reg;
    logic [SW-1:0]           d_s_reg;
    logic [P1W-1:0]          d_pay_reg;
    logic signed [EZW-1:0]   dlz;

    assign dlz = EZW'($signed(light_z_reg)) - EZW'($signed(sphere_z_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ez_reg  <= (dlz <<< FB) + $signed(EZW'(s1_root));
            d_s_reg   <= s1_root;
            d_pay_reg <= s1_pay;
        end
    end

    // ---------------- E: magnitude of z ----------------
    logic             e_vld_reg;
    logic             e_neg_reg;
    logic [EZW-1:0]   e_mag_reg;
    logic [SW-1:0]    e_s_reg;
    logic [P1W-1:0]   e_pay_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_neg_reg <= d_ez_reg[EZW-1];
            e_mag_reg <= d_ez_reg[EZW-1] ? EZW'(-d_ez_reg) : EZW'(d_ez_reg);
            e_s_reg   <= d_s_reg;
            e_pay_reg <= d_pay_reg;
        end
    end

    // ---------------- F: z products ----------------
    logic               f_vld_reg;
    logic               f_neg_reg;
    logic [PEZ_W-1:0]   f_pez_reg;
    logic [EZ2_W-1:0]   f_ez2_reg;
    logic [P1W-1:0]     f_pay_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_neg_reg <= e_neg_reg;
            f_pez_reg <= PEZ_W'(e_mag_reg) * PEZ_W'(e_s_reg);
            f_ez2_reg <= EZ2_W'(e_mag_reg) * EZ2_W'(e_mag_reg);
            f_pay_reg <= e_pay_reg;
        end
    end

    // ---------------- G: dot product and squared length ----------------
    logic                    g_vld_reg;
    logic                    g_hit_reg;
    logic signed [VW-1:0]    g_vdot_reg;
    logic [MW-1:0]           g_m2_reg;
    logic                    f_hit;
    logic signed [DXY_W-1:0] f_dxy;
    logic [EXY_W-1:0]        f_exy2;
    logic signed [VW-1:0]    g_base;
    logic signed [VW-1:0]    g_t;

    assign {f_hit, f_dxy, f_exy2} = f_pay_reg;
    assign g_base = VW'(f_dxy) <<< FB;
    assign g_t    = $signed(VW'(f_pez_reg >> FB));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_hit_reg  <= f_hit;
            // The z term is truncated toward zero before its sign is applied.
            g_vdot_reg <= f_neg_reg ? (g_base + g_t) : (g_base - g_t);
            g_m2_reg   <= (MW'(f_exy2) << FB) + MW'(f_ez2_reg >> FB);
        end
    end

    // ---------------- square root of the light distance ----------------
    logic            s2_vld;
    logic [LW-1:0]   s2_root;
    logic [P2W-1:0]  s2_pay;

    rsds_isqrt #(
        .IN_W  (L_IN),
        .PAY_W (P2W)
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_vld_reg),
        .in_rad    ({g_m2_reg, {FB{1'b0}}}),
        .in_pay    ({g_hit_reg, g_vdot_reg}),
        .out_valid (s2_vld),
        .out_root  (s2_root),
        .out_pay   (s2_pay)
    );

    // ---------------- H: denominator ----------------
    logic                 h_vld_reg;
    logic                 h_hit_reg;
    logic [DNW-1:0]       h_den_reg;
    logic signed [VW-1:0] h_vdot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_den_reg  <= DNW'(radius_reg) * DNW'(s2_root);
            h_hit_reg  <= s2_pay[P2W-1];
            h_vdot_reg <= $signed(s2_pay[VW-1:0]);
        end
    end

    // ---------------- I: channel numerators ----------------
    logic                  i_vld_reg;
    logic                  i_hit_reg;
    logic                  i_zero_reg;
    logic signed [RNW-1:0] i_nr_reg;
    logic signed [VW-1:0]  i_ng_reg;
    logic [DNW:0]          i_d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_hit_reg  <= h_hit_reg;
            i_zero_reg <= (h_den_reg == '0);
            i_nr_reg   <= $signed(RNW'(h_den_reg)) + RNW'(h_vdot_reg);
            i_ng_reg   <= h_vdot_reg;
            i_d2_reg   <= {h_den_reg, 1'b0};
        end
    end

    // ---------------- J: scale by 255 ----------------
    logic            j_vld_reg;
    logic            j_hit_reg;
    logic            j_zero_reg;
    logic [NW-1:0]   j_nr_reg;
    logic [NW-1:0]   j_ng_reg;
    logic [DNW:0]    j_d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_hit_reg  <= i_hit_reg;
            j_zero_reg <= i_zero_reg;
            j_nr_reg   <= (i_nr_reg > 0) ? (NW'(i_nr_reg) << 8) - NW'(i_nr_reg) : '0;
            j_ng_reg   <= (i_ng_reg > 0) ? (NW'(i_ng_reg) << 8) - NW'(i_ng_reg) : '0;
            j_d2_reg   <= i_d2_reg;
        end
    end

    // ---------------- K: restoring division, one quotient bit per stage ----------------
    logic [DVW-1:0]  dv_rr_reg [NDIV];
    logic [DVW-1:0]  dv_rg_reg [NDIV];
    logic [DVW-1:0]  dv_rr_next[NDIV];
    logic [DVW-1:0]  dv_rg_next[NDIV];
    logic [8:0]      dv_qr_reg [NDIV];
    logic [8:0]      dv_qg_reg [NDIV];
    logic [8:0]      dv_qr_next[NDIV];
    logic [8:0]      dv_qg_next[NDIV];
    logic [DNW:0]    dv_d2_reg [NDIV];
    logic [NDIV-1:0] dv_hit_reg;
    logic [NDIV-1:0] dv_zero_reg;
    logic [NDIV-1:0] dv_vld_reg;

    always_comb
    begin
        logic [DVW-1:0] src_rr;
        logic [DVW-1:0] src_rg;
        logic [8:0]     src_qr;
        logic [8:0]     src_qg;
        logic [DVW-1:0] sh;
        for (int k = 0; k < NDIV; k++)
        begin
            if (k == 0)
            begin
                src_rr = DVW'(j_nr_reg);
                src_rg = DVW'(j_ng_reg);
                src_qr = '0;
                src_qg = '0;
                sh     = DVW'(j_d2_reg) << (NDIV - 1);
            end
            else
            begin
                src_rr = dv_rr_reg[k-1];
                src_rg = dv_rg_reg[k-1];
                src_qr = dv_qr_reg[k-1];
                src_qg = dv_qg_reg[k-1];
                sh     = DVW'(dv_d2_reg[k-1]) << (NDIV - 1 - k);
            end
            if (src_rr >= sh)
            begin
                dv_rr_next[k] = src_rr - sh;
                dv_qr_next[k] = {src_qr[7:0], 1'b1};
            end
            else
            begin
                dv_rr_next[k] = src_rr;
                dv_qr_next[k] = {src_qr[7:0], 1'b0};
            end
            if (src_rg >= sh)
            begin
                dv_rg_next[k] = src_rg - sh;
                dv_qg_next[k] = {src_qg[7:0], 1'b1};
            end
            else
            begin
                dv_rg_next[k] = src_rg;
                dv_qg_next[k] = {src_qg[7:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NDIV; k++)
            begin
                dv_rr_reg[k] <= dv_rr_next[k];
                dv_rg_reg[k] <= dv_rg_next[k];
                dv_qr_reg[k] <= dv_qr_next[k];
                dv_qg_reg[k] <= dv_qg_next[k];
                dv_d2_reg[k] <= (k == 0) ? j_d2_reg : dv_d2_reg[k-1];
            end
            dv_hit_reg  <= {dv_hit_reg[NDIV-2:0], j_hit_reg};
            dv_zero_reg <= {dv_zero_reg[NDIV-2:0], j_zero_reg};
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            f_vld_reg  <= 1'b0;
            g_vld_reg  <= 1'b0;
            h_vld_reg  <= 1'b0;
            i_vld_reg  <= 1'b0;
            j_vld_reg  <= 1'b0;
            dv_vld_reg <= '0;
        end
        else if (en)
        begin
            a_vld_reg  <= in_beat;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            d_vld_reg  <= s1_vld;
            e_vld_reg  <= d_vld_reg;
            f_vld_reg  <= e_vld_reg;
            g_vld_reg  <= f_vld_reg;
            h_vld_reg  <= s2_vld;
            i_vld_reg  <= h_vld_reg;
            j_vld_reg  <= i_vld_reg;
            dv_vld_reg <= {dv_vld_reg[NDIV-2:0], j_vld_reg};
        end
    end

    // ---------------- color and output queue ----------------
    pix_t       pix;
    pix_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [8:0] qr_last;
    logic [8:0] qg_last;

    assign qr_last = dv_qr_reg[NDIV-1];
    assign qg_last = dv_qg_reg[NDIV-1];

    always_comb
    begin
        pix = '0;
        if (dv_hit_reg[NDIV-1])
        begin
            pix.hit = 1'b1;
            if (dv_zero_reg[NDIV-1])
            begin
                // Light sits on the surface point: cosine is taken as zero.
                pix.red = RED_UNLIT;
            end
            else
            begin
                pix.red   = qr_last[8] ? 8'hFF : qr_last[7:0];
                pix.green = qg_last[8] ? 8'hFF : qg_last[7:0];
                pix.blue  = pix.green;
            end
        end
    end

    // The pipeline only holds when the queue is full and a beat is at its end.
    assign en   = ~dv_vld_reg[NDIV-1] | (cnt_reg != 2'd2);
    assign push = en & dv_vld_reg[NDIV-1];
    assign pop  = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {fifo_reg[rd_ptr_reg].blue, fifo_reg[rd_ptr_reg].green,
                            fifo_reg[rd_ptr_reg].red};
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].hit;

    // ---------------- checks ----------------
    `RSDS_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && (cnt_reg == 2'd2))
    `RSDS_ASSERT_IMPL(a_miss_black, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
    `RSDS_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, cnt_reg == 2'd0, s_axis_tready)
    `RSDS_ASSERT_IMPL(a_count_tracks, clk, rst_n, push && !pop, ##1 (cnt_reg == $past(cnt_reg) + 2'd1))

endmodule

### verif/tb.sv
// Self-checking testbench for ray_sphere_diffuse_shader: APB setup, pixel stream in,
// shaded stream out, compared beat by beat against an in-bench fixed-point shading model.
// Depends on rsds_pkg and the RTL of the shader.
module tb
    import rsds_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    ray_sphere_diffuse_shader i_dut (.*);

    always #4 clk = ~clk;

    // Shadow copy of the configuration registers, raw bits.
    logic [10:0] cfg_shadow [7];
    logic [19:0] pixel_queue [$];
    pix_t        color_queue [$];
    int          send_idle = 0, recv_stall = 0;
    int          n_err = 0, n_results = 0, n_hits = 0, n_unlit = 0, wdog = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root, rem, trial;
        int i;
        root = 0;
        rem = 0;
        for (i = 0; i < 32; i++) begin
            rem = (rem << 2) | ((v >> (2 * (31 - i))) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Fixed-point product, truncated toward zero.
    function automatic longint mul_fx(longint a, longint b);
        longint p;
        p = a * b;
        return (p < 0) ? -((-p) >>> FB) : (p >>> FB);
    endfunction

    function automatic logic [7:0] chan(longint num, longint den);
        longint v;
        if (num <= 0) return 8'd0;
        v = (num * 255) / (den * 2);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic pix_t shade(logic [9:0] px, logic [9:0] py);
        longint cx, cy, cz, rad, lx, ly, lz, dx, dy, q, s, ex, ey, ez, dotv, m2, len, den;
        pix_t o;
        cx  = longint'($signed(cfg_shadow[REG_SPHERE_X]));
        cy  = longint'($signed(cfg_shadow[REG_SPHERE_Y]));
        cz  = longint'($signed(cfg_shadow[REG_SPHERE_Z]));
        rad = longint'(cfg_shadow[REG_RADIUS][9:0]);
        lx  = longint'($signed(cfg_shadow[REG_LIGHT_X]));
        ly  = longint'($signed(cfg_shadow[REG_LIGHT_Y]));
        lz  = longint'($signed(cfg_shadow[REG_LIGHT_Z]));
        dx  = longint'(px) - cx;
        dy  = longint'(py) - cy;
        q   = rad * rad - dx * dx - dy * dy;
        o   = '0;
        if (q <= 0) return o;
        s    = longint'(isqrt(longint'(q) << (2 * FB)));
        ex   = lx - longint'(px);
        ey   = ly - longint'(py);
        ez   = (lz - cz) * (64'sd1 <<< FB) + s;
        dotv = (ex * dx + ey * dy) * (64'sd1 <<< FB) - mul_fx(ez, s);
        m2   = (ex * ex + ey * ey) * (64'sd1 <<< FB) + mul_fx(ez, ez);
        len  = longint'(isqrt(longint'(m2) << FB));
        den  = rad * len;
        o.hit = 1'b1;
        if (den <= 0) begin
            o.red = RED_UNLIT;
        end else begin
            o.red   = chan(den + dotv, den);
            o.green = chan(dotv, den);
            o.blue  = o.green;
        end
        return o;
    endfunction

    // Pixel driver: holds a beat until it is taken, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin
        logic [19:0] pix;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                pix = pixel_queue.pop_front();
                s_axis_tdata  <= {4'd0, pix};
                s_axis_tvalid <= 1'b1;
                color_queue.push_back(shade(pix[9:0], pix[19:10]));
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and no-progress watchdog.
    always @(posedge clk)
    begin
        pix_t got, want;
        if (rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("%0t watchdog: no beat moved for %0d cycles", $realtime, WDOG_LIMIT);
                $display("[ray_sphere_diffuse_shader] ERROR");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata};
                n_results++;
                if (color_queue.size() == 0) begin
                    $display("%0t unexpected beat: expected none, actual %h", $realtime, got);
                    n_err++;
                end else begin
                    want = color_queue.pop_front();
                    if (got.hit) n_hits++;
                    if (got.hit && got.red == RED_UNLIT && got.green == 0) n_unlit++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.hit !== want.hit) begin
                        $display({"%0t mismatch: expected r%0d g%0d b%0d h%0d, ",
                                  "actual r%0d g%0d b%0d h%0d"},
                                 $realtime, want.red, want.green, want.blue, want.hit,
                                 got.red, got.green, got.blue, got.hit);
                        n_err++;
                    end
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * int'(idx));
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow[idx] = 11'(value);
    endtask

    task automatic set_scene(int sx, int sy, int sz, int r, int lx, int ly, int lz);
        write_reg(REG_SPHERE_X, sx);
        write_reg(REG_SPHERE_Y, sy);
        write_reg(REG_SPHERE_Z, sz);
        write_reg(REG_RADIUS, r);
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
    endtask

    task automatic push_pixel(int x, int y);
        if (x < 0) x = 0;
        if (x > 1023) x = 1023;
        if (y < 0) y = 0;
        if (y > 1023) y = 1023;
        pixel_queue.push_back({10'(y), 10'(x)});
    endtask

    // Mostly pixels around the sphere so that hits dominate; the rest uniform.
    task automatic push_random(int n);
        int c_x, c_y, r;
        c_x = int'($signed(cfg_shadow[REG_SPHERE_X]));
        c_y = int'($signed(cfg_shadow[REG_SPHERE_Y]));
        r   = int'(cfg_shadow[REG_RADIUS][9:0]);
        repeat (n) begin
            if ($urandom_range(99) < 30)
                push_pixel($urandom_range(1023), $urandom_range(1023));
            else
                push_pixel(c_x + $urandom_range(2 * r + 2) - r - 1,
                           c_y + $urandom_range(2 * r + 2) - r - 1);
        end
    endtask

    // Sender waits here until every expected color is back, then the pipe settles.
    task automatic drain();
        while (pixel_queue.size() > 0 || s_axis_tvalid || color_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            default: begin send_idle = 28; recv_stall = 28; end
        endcase
    endtask

    initial
    begin
        cfg_shadow[REG_SPHERE_X] = SPHERE_X_RST;
        cfg_shadow[REG_SPHERE_Y] = SPHERE_Y_RST;
        cfg_shadow[REG_SPHERE_Z] = SPHERE_Z_RST;
        cfg_shadow[REG_RADIUS]   = 11'(RADIUS_RST);
        cfg_shadow[REG_LIGHT_X]  = LIGHT_X_RST;
        cfg_shadow[REG_LIGHT_Y]  = LIGHT_Y_RST;
        cfg_shadow[REG_LIGHT_Z]  = LIGHT_Z_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels on the reset scene: corners, centre, tangent and near-edge rays.
        push_pixel(0, 0);
        push_pixel(1023, 1023);
        push_pixel(1023, 0);
        push_pixel(0, 1023);
        push_pixel(250, 250);
        push_pixel(300, 250);
        push_pixel(250, 200);
        push_pixel(299, 250);
        push_pixel(215, 285);
        push_pixel(286, 286);
        drain();

        // Light placed exactly on the surface point of the central ray.
        set_scene(500, 500, 100, 50, 500, 500, 50);
        push_pixel(500, 500);
        push_pixel(501, 500);
        // Sphere behind the origin.
        drain();
        set_scene(100, 100, -300, 60, 900, -1024, 1023);
        push_pixel(100, 100);
        push_pixel(140, 70);
        push_pixel(159, 100);
        drain();
        // Zero radius never hits.
        set_scene(10, 10, 0, 0, 0, 0, 0);
        push_pixel(10, 10);
        push_pixel(11, 10);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_scene(1023, 1023, -1024, 1023, -1024, -1024, 1023);
                1: set_scene(-1024, -1024, 1023, 1023, 1023, 1023, -1024);
                2: set_scene(512, 512, 0, 1, 512, 512, -1024);
                3: set_scene(0, 1023, 1023, 700, -1, 1023, 0);
                default: set_scene($urandom_range(1023), $urandom_range(1023),
                                   int'($signed(11'($urandom))), $urandom_range(1, 400),
                                   int'($signed(11'($urandom))), int'($signed(11'($urandom))),
                                   int'($signed(11'($urandom))));
            endcase
            set_idling(ph);
            push_random(50);
            drain();
        end
        set_idling(0);

        $display("Shaded %0d pixels over twelve scenes, %0d hits, %0d with the light on the %s",
                 n_results, n_hits, n_unlit, "surface.");
        if (n_err == 0 && color_queue.size() == 0)
            $display("[ray_sphere_diffuse_shader] OK");
        else
            $display("[ray_sphere_diffuse_shader] ERROR");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/rsds_pkg.sv
rtl/rsds_isqrt.sv
rtl/ray_sphere_diffuse_shader.sv
verif/tb.sv
